// File: rtl/tcch_pkg.sv
`default_nettype none
package tcch_pkg;
    localparam int CordicSteps = 16;
    localparam int AtanEntries = 24;
    localparam int NumIter = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
    localparam int AngW = 15;
    localparam int FldW = 16;
    localparam int ZW = 26;
    localparam int ScW = 19;
    localparam int HW = 52;
    localparam int AW = 56;
    localparam logic signed [AngW-1:0] Deg90In = 15'sd5760;
    localparam logic signed [AngW-1:0] Deg180In = 15'sd11520;
    localparam logic signed [AngW+1:0] Deg360In = 17'sd23040;
    localparam logic signed [ZW-1:0] Deg180Z = 26'sd11796480;
    localparam logic signed [ScW-1:0] CordicX0 = 19'sd39797;

    typedef struct packed {
        logic signed [ScW-1:0] x;
        logic signed [ScW-1:0] y;
        logic signed [ZW-1:0] z;
        logic neg;
    } t_sc;

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] t [0:23];
        t = '{26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
              26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667,
              26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
              26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0};
        return t[i];
    endfunction
endpackage
`default_nettype wire

// File: rtl/tcch_if.sv
`default_nettype none
interface tcch_in_if (input wire logic i_clk);
    logic valid;
    logic ready;
    logic signed [14:0] pitch_deg;
    logic signed [14:0] roll_deg;
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    modport source (output valid, pitch_deg, roll_deg, field_x, field_y, field_z,
                    input ready);
    modport sink (input valid, pitch_deg, roll_deg, field_x, field_y, field_z,
                  output ready);
endinterface

interface tcch_out_if (input wire logic i_clk);
    logic valid;
    logic ready;
    logic signed [14:0] heading_deg;
    modport source (output valid, heading_deg, input ready);
    modport sink (input valid, heading_deg, output ready);
endinterface
`default_nettype wire

// File: rtl/tilt_compensated_compass_heading.sv
// throughput: one request per cycle; a stall at the output freezes every stage at once
// reset: synchronous active-low i_rst_n clears all stage valid bits; payload is not reset
// the pipeline holds no state between requests, so nothing else needs clearing
`default_nettype none
module tilt_compensated_compass_heading (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcch_in_if.sink   i_req,
    tcch_out_if.source o_rsp
);
    localparam int N = tcch_pkg::NumIter;
    localparam int ScW = tcch_pkg::ScW;
    localparam int ZW = tcch_pkg::ZW;
    localparam int HW = tcch_pkg::HW;
    localparam int AW = tcch_pkg::AW;
    // stage map: 0 reduce, 1..N sincos, N+1 products, N+2 triple products,
    // N+3 sums, N+4 atan2 setup, N+5..2N+4 vectoring, 2N+5 round/clamp
    localparam int NS = 2 * N + 6;

    logic [NS-1:0] r_vld;
    logic          w_adv;

    // global stall: whole pipe advances when the output slot is free
    assign w_adv = !r_vld[NS-1] || o_rsp.ready;
    assign i_req.ready = w_adv;
    assign o_rsp.valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], i_req.valid};
        end
    end

    // angle wrap and fold into +/-90 degrees
    function automatic tcch_pkg::t_sc reduce(input logic signed [14:0] a_in);
        logic signed [16:0] a;
        tcch_pkg::t_sc s;
        a = 17'(a_in);
        s.neg = 1'b0;
        if (a >= 17'(tcch_pkg::Deg180In)) a = a - tcch_pkg::Deg360In;
        if (a < -17'(tcch_pkg::Deg180In)) a = a + tcch_pkg::Deg360In;
        if (a > 17'(tcch_pkg::Deg90In)) begin
            a = a - 17'(tcch_pkg::Deg180In);
            s.neg = 1'b1;
        end
        if (a < -17'(tcch_pkg::Deg90In)) begin
            a = a + 17'(tcch_pkg::Deg180In);
            s.neg = 1'b1;
        end
        s.x = tcch_pkg::CordicX0;
        s.y = '0;
        s.z = ZW'(a) <<< 10;
        return s;
    endfunction

    function automatic tcch_pkg::t_sc rot_step(input tcch_pkg::t_sc s, input int i);
        tcch_pkg::t_sc o;
        o = s;
        if (s.z >= 0) begin
            o.x = s.x - (s.y >>> i);
            o.y = s.y + (s.x >>> i);
            o.z = s.z - tcch_pkg::atan_tab(i);
        end else begin
            o.x = s.x + (s.y >>> i);
            o.y = s.y - (s.x >>> i);
            o.z = s.z + tcch_pkg::atan_tab(i);
        end
        return o;
    endfunction

    // ---------------- sin/cos pipelines (pitch and roll side by side)
    tcch_pkg::t_sc r_p [0:N];
    tcch_pkg::t_sc r_r [0:N];
    logic signed [15:0] r_mx [0:N];
    logic signed [15:0] r_my [0:N];
    logic signed [15:0] r_mz [0:N];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p[0]  <= reduce(i_req.pitch_deg);
            r_r[0]  <= reduce(i_req.roll_deg);
            r_mx[0] <= i_req.field_x;
            r_my[0] <= i_req.field_y;
            r_mz[0] <= i_req.field_z;
            for (int k = 0; k < N; k++) begin
                r_p[k+1]  <= rot_step(r_p[k], k);
                r_r[k+1]  <= rot_step(r_r[k], k);
                r_mx[k+1] <= r_mx[k];
                r_my[k+1] <= r_my[k];
                r_mz[k+1] <= r_mz[k];
            end
        end
    end

    logic signed [ScW-1:0] w_cp, w_sp, w_cr, w_sr;
    assign w_cp = r_p[N].neg ? -r_p[N].x : r_p[N].x;
    assign w_sp = r_p[N].neg ? -r_p[N].y : r_p[N].y;
    assign w_cr = r_r[N].neg ? -r_r[N].x : r_r[N].x;
    assign w_sr = r_r[N].neg ? -r_r[N].y : r_r[N].y;

    // ---------------- products, one multiplier level per stage
    logic signed [35:0] r_mxcp, r_mzsp, r_mycr, r_mxsp, r_mzcp;
    logic signed [ScW-1:0] r_sr;
    logic signed [HW-1:0] r_t1, r_t2, r_t3, r_xq;
    logic signed [HW-1:0] r_xh, r_yh;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mxcp <= 36'(r_mx[N]) * 36'(w_cp);
            r_mzsp <= 36'(r_mz[N]) * 36'(w_sp);
            r_mycr <= 36'(r_my[N]) * 36'(w_cr);
            r_mxsp <= 36'(r_mx[N]) * 36'(w_sp);
            r_mzcp <= 36'(r_mz[N]) * 36'(w_cp);
            r_sr   <= w_sr;
            r_t1   <= HW'(r_mxsp) * HW'(r_sr);
            r_t2   <= HW'(r_mzcp) * HW'(r_sr);
            r_t3   <= HW'(r_mycr) <<< 16;
            r_xq   <= (HW'(r_mxcp) + HW'(r_mzsp)) <<< 16;
            r_xh   <= r_xq;
            r_yh   <= r_t1 + r_t3 - r_t2;
        end
    end

    // ---------------- atan2 vectoring pipeline
    typedef struct packed {
        logic signed [AW-1:0] x;
        logic signed [AW-1:0] y;
        logic signed [ZW-1:0] z;
        logic zero;
    } t_vec;

    t_vec r_v [0:N];
    t_vec w_v0;

    always_comb begin
        logic signed [AW-1:0] x, y;
        x = AW'(r_xh);
        y = -AW'(r_yh);
        w_v0.zero = (x == 0) && (y == 0);
        w_v0.z = '0;
        if (x < 0) begin
            w_v0.z = (y >= 0) ? tcch_pkg::Deg180Z : -tcch_pkg::Deg180Z;
            x = -x;
            y = -y;
        end
        w_v0.x = x;
        w_v0.y = y;
    end

    function automatic t_vec vec_step(input t_vec s, input int i);
        t_vec o;
        o = s;
        if (s.y < 0) begin
            o.x = s.x - (s.y >>> i);
            o.y = s.y + (s.x >>> i);
            o.z = s.z - tcch_pkg::atan_tab(i);
        end else begin
            o.x = s.x + (s.y >>> i);
            o.y = s.y - (s.x >>> i);
            o.z = s.z + tcch_pkg::atan_tab(i);
        end
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v[0] <= w_v0;
            for (int k = 0; k < N; k++) begin
                r_v[k+1] <= vec_step(r_v[k], k);
            end
        end
    end

    // ---------------- round to degrees*64 and clamp
    logic signed [14:0] r_head;
    logic signed [ZW-1:0] w_h;
    // both arms signed so the shift floors
    assign w_h = r_v[N].zero ? ZW'(0) : ((r_v[N].z + ZW'(512)) >>> 10);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_h > ZW'(tcch_pkg::Deg180In)) r_head <= tcch_pkg::Deg180In;
            else if (w_h < -ZW'(tcch_pkg::Deg180In)) r_head <= -tcch_pkg::Deg180In;
            else r_head <= w_h[14:0];
        end
    end
    assign o_rsp.heading_deg = r_head;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.heading_deg))
        else $error("result changed under stall");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.heading_deg <= tcch_pkg::Deg180In) &&
                        (o_rsp.heading_deg >= -tcch_pkg::Deg180In))
        else $error("heading out of range");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp.valid |-> i_req.ready)
        else $error("input blocked with empty output");
`endif
endmodule
`default_nettype wire
